FILE: rtl/fsh_pkg.sv
// Package with the transaction types, constants and helpers of the FNV string hash unit.
package fsh_pkg;

	// Hash constants: the prime is 2^24 + 403, so a multiply is a sum of shifted copies.
	localparam logic [63:0] HASH_BASIS = 64'd2166136261;
	localparam int unsigned ACC_W = 64;
	localparam int unsigned BOUND_W = 62;
	localparam int unsigned CHAR_W = 8;

	// Shifted copies added to the accumulator on top of the unshifted one.
	localparam int unsigned MUL_TERMS = 5;
	localparam int unsigned MUL_IDX_W = $clog2(MUL_TERMS);
	localparam int unsigned SHIFT_W = 5;
	localparam logic [SHIFT_W-1:0] MUL_SHIFT [MUL_TERMS] =
		'{5'd1, 5'd4, 5'd7, 5'd8, 5'd24};

	// One restoring division step per accumulator bit.
	localparam int unsigned DIV_STEPS = ACC_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// ASCII upper-case range.
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_CASE_OFS = 8'h20;

	// Input transaction.
	typedef struct packed {
		logic [CHAR_W-1:0]  char_code;
		logic               has_char;
		logic               fold_case;
		logic               last_char;
		logic [BOUND_W-1:0] mod_bound;
	} in_t;

	// Result transaction.
	typedef struct packed {
		logic [BOUND_W-1:0] hash_value;
		logic               bound_error;
	} out_t;

	// Request to and response from the shared adder unit.
	typedef struct packed {
		logic [ACC_W-1:0] a;
		logic [ACC_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [ACC_W-1:0] sum;
		logic             carry;
	} alu_rsp_t;

	// Maps ASCII upper case to lower case when folding is selected.
	function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
			input logic fold);
		logic [CHAR_W-1:0] r;
		r = c;
		if (fold && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + CHAR_CASE_OFS;
		end
		return r;
	endfunction

endpackage

FILE: rtl/fsh_alu.sv
// Shared 64-bit adder and subtractor used by both the multiply and the division sequences.
module fsh_alu (
	input  fsh_pkg::alu_req_t req,
	output fsh_pkg::alu_rsp_t rsp
);

	logic [fsh_pkg::ACC_W-1:0] b_eff;
	logic [fsh_pkg::ACC_W:0]   total;

	// Subtraction is addition of the inverted operand with a carry in; carry out means a >= b.
	assign b_eff = req.sub ? ~req.b : req.b;
	assign total = {1'b0, req.a} + {1'b0, b_eff} + {{fsh_pkg::ACC_W{1'b0}}, req.sub};
	assign rsp.sum = total[fsh_pkg::ACC_W-1:0];
	assign rsp.carry = total[fsh_pkg::ACC_W];

endmodule

FILE: rtl/fnv_string_hash_mod_unit.sv
// Top level of the FNV-1 string hash unit with a sequencer around one shared adder.
//
//   Channel | Direction | Handshake           | Payload
//   in      | input     | in_valid / in_ready   | in_data  (fsh_pkg::in_t)
//   out     | output    | out_valid / out_ready | out_data (fsh_pkg::out_t)
//
// A character is accepted and then multiplied by the prime as a sum of shifted copies on the adder.
// A last transaction adds restoring division on the same adder and a final state that loads
// the result register; a zero bound skips the division.
// Reset loads the accumulator with the offset basis and empties the result register.
// The result register lets the next transaction enter while a result waits; a finished
// result is held in the final state until the result register is free.
module fnv_string_hash_mod_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fsh_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output fsh_pkg::out_t out_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]                      state_q;
	logic [fsh_pkg::ACC_W-1:0]       acc_q;
	logic [fsh_pkg::ACC_W-1:0]       prod_q;
	logic [fsh_pkg::BOUND_W-1:0]     rem_q;
	logic [fsh_pkg::BOUND_W-1:0]     bound_q;
	logic [fsh_pkg::CHAR_W-1:0]      ch_q;
	logic                            last_q;
	logic                            err_q;
	logic [fsh_pkg::MUL_IDX_W-1:0]   mul_idx_q;
	logic [fsh_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	fsh_pkg::out_t                   out_q;
	logic                            out_valid_q;

	fsh_pkg::alu_req_t               alu_req;
	fsh_pkg::alu_rsp_t               alu_rsp;
	logic [fsh_pkg::ACC_W-1:0]       rem_shift;
	logic                            in_fire;
	logic                            fin_fire;

	// Handshake outputs.
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Partial remainder shifted left with the next dividend bit brought in.
	assign rem_shift = {1'b0, rem_q, acc_q[fsh_pkg::ACC_W-1]};

	// Operand selection for the shared adder.
	always_comb begin
		alu_req.a = prod_q;
		alu_req.b = acc_q << fsh_pkg::MUL_SHIFT[mul_idx_q];
		alu_req.sub = 1'b0;
		if (state_q == ST_DIV) begin
			alu_req.a = rem_shift;
			alu_req.b = {{(fsh_pkg::ACC_W-fsh_pkg::BOUND_W){1'b0}}, bound_q};
			alu_req.sub = 1'b1;
		end
	end

	fsh_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Sequencer and accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q <= fsh_pkg::HASH_BASIS;
			mul_idx_q <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						mul_idx_q <= '0;
						div_cnt_q <= '0;
						if (in_data.has_char) begin
							state_q <= ST_MUL;
						end else if (in_data.last_char) begin
							state_q <= (in_data.mod_bound == '0) ? ST_FIN : ST_DIV;
						end
					end
				end
				ST_MUL: begin
					if (mul_idx_q == fsh_pkg::MUL_IDX_W'(fsh_pkg::MUL_TERMS - 1)) begin
						acc_q <= alu_rsp.sum ^
							{{(fsh_pkg::ACC_W-fsh_pkg::CHAR_W){1'b0}}, ch_q};
						if (last_q) begin
							state_q <= err_q ? ST_FIN : ST_DIV;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						mul_idx_q <= mul_idx_q + 1'b1;
					end
				end
				ST_DIV: begin
					acc_q <= acc_q << 1;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == fsh_pkg::DIV_CNT_W'(fsh_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						acc_q <= fsh_pkg::HASH_BASIS;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the current transaction.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q <= fsh_pkg::fold_char(in_data.char_code, in_data.fold_case);
			last_q <= in_data.last_char;
			bound_q <= in_data.mod_bound;
			err_q <= (in_data.mod_bound == '0);
			prod_q <= acc_q;
			rem_q <= '0;
		end else if (state_q == ST_MUL) begin
			prod_q <= alu_rsp.sum;
		end else if (state_q == ST_DIV) begin
			rem_q <= alu_rsp.carry ? alu_rsp.sum[fsh_pkg::BOUND_W-1:0]
				: rem_shift[fsh_pkg::BOUND_W-1:0];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			out_q.hash_value <= err_q ? '0 : rem_q;
			out_q.bound_error <= err_q;
		end
	end

	// The partial remainder always stays below the divisor during division.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && !err_q |-> rem_q < bound_q)
		else $error("remainder not below bound during division");

	// A result appears only out of the final state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the final state");

	// A character always starts the multiply sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.has_char |=> state_q == ST_MUL)
		else $error("character accepted without multiply");

	// An error result carries a zero hash value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.bound_error |-> out_q.hash_value == '0)
		else $error("error result with non-zero value");

endmodule
